FILE: sv/ota_rx_pkg.sv
// Shared types, codes and helpers for the update packet receiver.
`default_nettype none

package ota_rx_pkg;

	localparam int SECTOR_SHIFT = 12;
	localparam int SECTOR_W     = 24 - SECTOR_SHIFT;

	typedef enum logic [1:0] {
		PH_NONE   = 2'd0,
		PH_OPEN   = 2'd1,
		PH_CLOSED = 2'd2
	} phase_t;

	localparam logic [1:0] REG_BEGIN_CODE  = 2'd0;
	localparam logic [1:0] REG_END_CODE    = 2'd1;
	localparam logic [1:0] REG_DATA_CODE   = 2'd2;
	localparam logic [1:0] REG_REGION_BASE = 2'd3;

	localparam logic [7:0]  BEGIN_CODE_RST  = 8'd0;
	localparam logic [7:0]  END_CODE_RST    = 8'd1;
	localparam logic [7:0]  DATA_CODE_RST   = 8'd2;
	localparam logic [31:0] REGION_BASE_RST = 32'd0;

	// Input item, packet_kind in the lowest bits.
	typedef struct packed {
		logic [7:0]  check_byte;
		logic [63:0] payload_high;
		logic [63:0] payload_low;
		logic [23:0] addr_or_size;
		logic [7:0]  image_version;
		logic [7:0]  device_kind;
		logic [7:0]  packet_kind;
	} in_t;

	// Result item, status in the lowest bit, zero pad to 208 bits.
	typedef struct packed {
		logic [4:0]  pad;
		logic [23:0] header_size;
		logic [7:0]  header_version;
		logic        header_req;
		logic [63:0] data_high;
		logic [63:0] data_low;
		logic [31:0] write_addr;
		logic        write_req;
		logic [6:0]  erase_index;
		logic        erase_req;
		logic        status;
	} out_t;

	// Modulo-256 sum of the eight bytes of a word.
	function automatic logic [7:0] sum_bytes64(input logic [63:0] v);
		logic [7:0] s;
		s = 8'd0;
		for (int i = 0; i < 8; i++) begin
			s = s + v[8*i +: 8];
		end
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: sv/ota_packet_receiver.sv
// A packet passes the input register and then the result register before its result is valid.
// One packet per cycle while the output is not stalled; an accepted END holds off input until
//   the sector map is swept to all pending, one entry per cycle through its write port.
// Reset: no session open, code registers to their defaults; a sweep then clears the sector map
//   with input held off. Configuration writes are taken at any time.
`default_nettype none

module ota_packet_receiver #(
	parameter int MAP_SECTORS = 128
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_wdata,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// packet_kind, device_kind, image_version, addr_or_size, payload_low, payload_high,
	// check_byte
	input  wire logic [183:0]  s_axis_tdata,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// status, erase_req, erase_index, write_req, write_addr, data_low, data_high,
	// header_req, header_version, header_size, zero pad
	output logic [207:0]       m_axis_tdata
);

	localparam int AW = (MAP_SECTORS > 1) ? $clog2(MAP_SECTORS) : 1;
	localparam int SW1 = ota_rx_pkg::SECTOR_W + 1;
	localparam logic [AW-1:0]  LAST_ENTRY = AW'(MAP_SECTORS - 1);
	localparam logic [SW1-1:0] MAP_LIMIT  = SW1'(MAP_SECTORS);

	// configuration
	logic [7:0]  begin_code_q;
	logic [7:0]  end_code_q;
	logic [7:0]  data_code_q;
	logic [31:0] region_base_q;

	// session
	ota_rx_pkg::phase_t phase_q, phase_nx;
	logic [7:0] sess_dev_q;
	logic [7:0] sess_ver_q;

	// sector map sweep
	logic          sweep_q;
	logic [AW-1:0] sweep_addr_q;
	logic          sweep_val_q;
	logic          pend_mem [MAP_SECTORS];

	// stages
	logic              v_s1;
	ota_rx_pkg::in_t   pkt_s1;
	logic              pend_rd_s1;
	logic              clr_fwd_s1;
	logic              v_s2;
	ota_rx_pkg::out_t  res_s2;

	ota_rx_pkg::in_t   pkt_in;
	ota_rx_pkg::out_t  res_nx;
	logic [ota_rx_pkg::SECTOR_W-1:0] sec_in, sec_s1;
	logic [AW-1:0] rd_addr, clr_addr;
	logic          in_acc, s1_adv, clr_we;
	logic [7:0]    sum_s1;
	logic          chk_ok, is_begin, is_end, is_data;
	logic          begin_ok, end_ok, data_ok, in_map, erase_s1;

	assign pkt_in  = ota_rx_pkg::in_t'(s_axis_tdata);
	assign sec_in  = pkt_in.addr_or_size[23:ota_rx_pkg::SECTOR_SHIFT];
	assign rd_addr = sec_in[AW-1:0];

	assign s1_adv = v_s1 && (!v_s2 || m_axis_tready);
	// hold input while the map sweeps, while an END waits to start the sweep, and while the input register is stalled
	assign s_axis_tready = !sweep_q && (!v_s1 || (s1_adv && !end_ok));
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// decode of the packet in the input register
	assign sum_s1 = pkt_s1.packet_kind + pkt_s1.device_kind + pkt_s1.image_version
		+ pkt_s1.addr_or_size[7:0] + pkt_s1.addr_or_size[15:8] + pkt_s1.addr_or_size[23:16]
		+ ota_rx_pkg::sum_bytes64(pkt_s1.payload_low)
		+ ota_rx_pkg::sum_bytes64(pkt_s1.payload_high);
	assign chk_ok   = (sum_s1 == pkt_s1.check_byte);
	assign is_begin = (pkt_s1.packet_kind == begin_code_q);
	assign is_end   = !is_begin && (pkt_s1.packet_kind == end_code_q);
	assign is_data  = !is_begin && !is_end && (pkt_s1.packet_kind == data_code_q);
	assign begin_ok = v_s1 && chk_ok && is_begin;
	assign end_ok   = v_s1 && chk_ok && is_end && (phase_q == ota_rx_pkg::PH_OPEN);
	assign data_ok  = v_s1 && chk_ok && is_data && (phase_q == ota_rx_pkg::PH_OPEN)
		&& (pkt_s1.device_kind == sess_dev_q) && (pkt_s1.image_version == sess_ver_q);

	assign sec_s1   = pkt_s1.addr_or_size[23:ota_rx_pkg::SECTOR_SHIFT];
	assign in_map   = ({1'b0, sec_s1} < MAP_LIMIT);
	assign erase_s1 = data_ok && in_map && pend_rd_s1 && !clr_fwd_s1;
	assign clr_we   = s1_adv && erase_s1;
	assign clr_addr = sec_s1[AW-1:0];

	always_comb begin
		res_nx = '0;
		res_nx.status = !(begin_ok || end_ok || data_ok);
		if (data_ok) begin
			res_nx.erase_req   = erase_s1;
			res_nx.erase_index = erase_s1 ? sec_s1[6:0] : 7'd0;
			res_nx.write_req   = 1'b1;
			res_nx.write_addr  = region_base_q + {8'd0, pkt_s1.addr_or_size};
		end
		if (data_ok || end_ok) begin
			res_nx.data_low  = pkt_s1.payload_low;
			res_nx.data_high = pkt_s1.payload_high;
		end
		if (end_ok) begin
			res_nx.header_req     = 1'b1;
			res_nx.header_version = pkt_s1.image_version;
			res_nx.header_size    = pkt_s1.addr_or_size;
		end
	end

	always_comb begin
		phase_nx = phase_q;
		if (s1_adv && begin_ok) begin
			phase_nx = ota_rx_pkg::PH_OPEN;
		end else if (s1_adv && end_ok) begin
			phase_nx = ota_rx_pkg::PH_CLOSED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ota_rx_pkg::PH_NONE;
			sess_dev_q <= 8'd0;
			sess_ver_q <= 8'd0;
		end else begin
			phase_q <= phase_nx;
			if (s1_adv && (begin_ok || end_ok)) begin
				sess_dev_q <= pkt_s1.device_kind;
				sess_ver_q <= pkt_s1.image_version;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_code_q  <= ota_rx_pkg::BEGIN_CODE_RST;
			end_code_q    <= ota_rx_pkg::END_CODE_RST;
			data_code_q   <= ota_rx_pkg::DATA_CODE_RST;
			region_base_q <= ota_rx_pkg::REGION_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ota_rx_pkg::REG_BEGIN_CODE:  begin_code_q  <= cfg_wdata[7:0];
				ota_rx_pkg::REG_END_CODE:    end_code_q    <= cfg_wdata[7:0];
				ota_rx_pkg::REG_DATA_CODE:   data_code_q   <= cfg_wdata[7:0];
				ota_rx_pkg::REG_REGION_BASE: region_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			sweep_val_q  <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			if (sweep_q) begin
				sweep_addr_q <= sweep_addr_q + 1'b1;
				if (sweep_addr_q == LAST_ENTRY) begin
					sweep_q      <= 1'b0;
					sweep_addr_q <= '0;
				end
			end else if (s1_adv && end_ok) begin
				sweep_q      <= 1'b1;
				sweep_val_q  <= 1'b1;
				sweep_addr_q <= '0;
			end
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				v_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// sector map: one write port (sweep or clear), one registered read
	always_ff @(posedge clk) begin
		if (sweep_q) begin
			pend_mem[sweep_addr_q] <= sweep_val_q;
		end else if (clr_we) begin
			pend_mem[clr_addr] <= 1'b0;
		end
		if (in_acc) begin
			pend_rd_s1 <= pend_mem[rd_addr];
			// bypass a clear of the same sector committed at this edge
			clr_fwd_s1 <= clr_we && (clr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pkt_s1 <= pkt_in;
		end
		if (s1_adv) begin
			res_s2 <= res_nx;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = res_s2;

endmodule

`default_nettype wire

FILE: sv/ota_rx_chk.sv
// Port-level checker for the update packet receiver, bound to the top level.
`default_nettype none

module ota_rx_chk (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [207:0] m_axis_tdata
);

	ota_rx_pkg::out_t res;

	assign res = ota_rx_pkg::out_t'(m_axis_tdata);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status |-> (m_axis_tdata[207:1] == '0))
		else $error("rejected packet carries nonzero fields");

	a_erase_with_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.erase_req |-> res.write_req && !res.status)
		else $error("erase without data write");

	a_write_header_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res.write_req && res.header_req))
		else $error("data write and header write in one result");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.pad == '0))
		else $error("pad bits set");

endmodule

bind ota_packet_receiver ota_rx_chk u_ota_rx_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the update packet receiver: directed and random sessions.
`timescale 1ns / 100ps

module tb_top;

	localparam int MAP_SECTORS = 128;
	localparam int MAP_AW      = $clog2(MAP_SECTORS);
	localparam int IDLE_GAP    = 4;
	localparam int CYCLE_LIMIT = 1000000;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [31:0]   cfg_wdata;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	// packet_kind, device_kind, image_version, addr_or_size, payload_low, payload_high,
	// check_byte
	logic [183:0]  s_axis_tdata;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	// status, erase_req, erase_index, write_req, write_addr, data_low, data_high,
	// header_req, header_version, header_size, zero pad
	logic [207:0]  m_axis_tdata;

	// Predicted receiver state and register copies
	logic [7:0]             code_begin;
	logic [7:0]             code_end;
	logic [7:0]             code_data;
	logic [31:0]            base_addr;
	ota_rx_pkg::phase_t     sess_phase;
	logic [7:0]             sess_dev;
	logic [7:0]             sess_ver;
	logic [23:0]            sess_size;
	logic [63:0]            sess_sig_lo;
	logic [63:0]            sess_sig_hi;
	logic [MAP_SECTORS-1:0] erase_pending;

	ota_rx_pkg::out_t expected_results[$];
	int   errors = 0;
	int   cycle_count = 0;
	int   src_idle = 0;
	int   sink_stall = 0;

	ota_packet_receiver #(
		.MAP_SECTORS(MAP_SECTORS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [7:0] packet_byte_sum(ota_rx_pkg::in_t p);
		logic [7:0]   s;
		logic [175:0] body;
		body = p[175:0];
		s = 8'd0;
		for (int i = 0; i < 22; i++) begin
			s = s + body[8*i +: 8];
		end
		return s;
	endfunction

	function automatic ota_rx_pkg::in_t make_packet(logic [7:0] kind, logic [7:0] dev,
			logic [7:0] ver, logic [23:0] aos, logic [63:0] plo, logic [63:0] phi,
			logic corrupt);
		ota_rx_pkg::in_t p;
		p.packet_kind   = kind;
		p.device_kind   = dev;
		p.image_version = ver;
		p.addr_or_size  = aos;
		p.payload_low   = plo;
		p.payload_high  = phi;
		p.check_byte    = packet_byte_sum(p);
		if (corrupt)
			p.check_byte = p.check_byte ^ 8'($urandom_range(1, 255));
		return p;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Bias toward the all-zero and all-one bytes
	function automatic logic [7:0] rand_byte();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Mostly low sectors so that repeats hit both pending and cleared map bits
	function automatic logic [23:0] rand_offset();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return {12'($urandom_range(0, 7)), 12'($urandom)};
		if (pick < 90)
			return {12'($urandom_range(0, MAP_SECTORS - 1)), 12'($urandom)};
		return 24'($urandom);
	endfunction

	function automatic ota_rx_pkg::out_t predict_result(ota_rx_pkg::in_t p);
		ota_rx_pkg::out_t r;
		logic [11:0]      sec;
		r = '0;
		r.status = 1'b1;
		if (packet_byte_sum(p) != p.check_byte)
			return r;
		if (p.packet_kind == code_begin) begin
			sess_phase  = ota_rx_pkg::PH_OPEN;
			sess_dev    = p.device_kind;
			sess_ver    = p.image_version;
			sess_size   = p.addr_or_size;
			sess_sig_lo = p.payload_low;
			sess_sig_hi = p.payload_high;
			r.status    = 1'b0;
		end else if (p.packet_kind == code_end) begin
			if (sess_phase == ota_rx_pkg::PH_OPEN) begin
				sess_phase       = ota_rx_pkg::PH_CLOSED;
				sess_dev         = p.device_kind;
				sess_ver         = p.image_version;
				sess_size        = p.addr_or_size;
				sess_sig_lo      = p.payload_low;
				sess_sig_hi      = p.payload_high;
				erase_pending    = '1;
				r.status         = 1'b0;
				r.data_low       = p.payload_low;
				r.data_high      = p.payload_high;
				r.header_req     = 1'b1;
				r.header_version = p.image_version;
				r.header_size    = p.addr_or_size;
			end
		end else if (p.packet_kind == code_data) begin
			if (sess_phase == ota_rx_pkg::PH_OPEN && p.device_kind == sess_dev
					&& p.image_version == sess_ver) begin
				sec = p.addr_or_size[23:12];
				if (sec < MAP_SECTORS) begin
					if (erase_pending[sec[MAP_AW-1:0]]) begin
						erase_pending[sec[MAP_AW-1:0]] = 1'b0;
						r.erase_req   = 1'b1;
						r.erase_index = sec[6:0];
					end
				end
				r.status     = 1'b0;
				r.write_req  = 1'b1;
				r.write_addr = base_addr + {8'h00, p.addr_or_size};
				r.data_low   = p.payload_low;
				r.data_high  = p.payload_high;
			end
		end
		return r;
	endfunction

	function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			errors++;
		end
	endfunction

	function automatic void check_result(ota_rx_pkg::out_t got);
		ota_rx_pkg::out_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result with nothing pending, expected none, got %h", $time, got);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		check_field("status", 64'(want.status), 64'(got.status));
		check_field("erase_req", 64'(want.erase_req), 64'(got.erase_req));
		check_field("erase_index", 64'(want.erase_index), 64'(got.erase_index));
		check_field("write_req", 64'(want.write_req), 64'(got.write_req));
		check_field("write_addr", 64'(want.write_addr), 64'(got.write_addr));
		check_field("data_low", want.data_low, got.data_low);
		check_field("data_high", want.data_high, got.data_high);
		check_field("header_req", 64'(want.header_req), 64'(got.header_req));
		check_field("header_version", 64'(want.header_version), 64'(got.header_version));
		check_field("header_size", 64'(want.header_size), 64'(got.header_size));
		check_field("pad", 64'(want.pad), 64'(got.pad));
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result(ota_rx_pkg::out_t'(m_axis_tdata));
		m_axis_tready <= ($urandom_range(99) >= sink_stall);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Called and returning right after a rising edge
	task automatic send_packet(ota_rx_pkg::in_t pkt);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pkt;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_results.push_back(predict_result(pkt));
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ota_rx_pkg::REG_BEGIN_CODE:  code_begin = val[7:0];
			ota_rx_pkg::REG_END_CODE:    code_end   = val[7:0];
			ota_rx_pkg::REG_DATA_CODE:   code_data  = val[7:0];
			ota_rx_pkg::REG_REGION_BASE: base_addr  = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_regs(logic [7:0] b, logic [7:0] e, logic [7:0] d, logic [31:0] base);
		wait_idle();
		write_reg(ota_rx_pkg::REG_BEGIN_CODE, {24'h0, b});
		write_reg(ota_rx_pkg::REG_END_CODE, {24'h0, e});
		write_reg(ota_rx_pkg::REG_DATA_CODE, {24'h0, d});
		write_reg(ota_rx_pkg::REG_REGION_BASE, base);
	endtask

	task automatic program_random_regs(logic [31:0] base);
		logic [7:0] b, e, d;
		do begin
			b = 8'($urandom);
			e = 8'($urandom);
			d = 8'($urandom);
		end while (b == e || b == d || e == d);
		program_regs(b, e, d, base);
	endtask

	task automatic test_session_basics();
		// No session open yet, map empty after reset
		send_packet(make_packet(code_data, 8'h00, 8'h00, 24'h000000, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_end, 8'h00, 8'h00, 24'h000100, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_begin, 8'h12, 8'h34, 24'h001000, rand64(), rand64(), 1'b1));
		send_packet(make_packet(code_begin, 8'hFF, 8'hFF, 24'hFFFFFF, '1, '1, 1'b0));
		send_packet(make_packet(code_data, 8'hFF, 8'hFF, 24'h000000, '0, '0, 1'b0));
		send_packet(make_packet(code_data, 8'hFE, 8'hFF, 24'h000010, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'hFF, 8'hFE, 24'h000020, rand64(), rand64(), 1'b0));
		send_packet(make_packet(8'hFF, 8'hFF, 8'hFF, 24'h000030, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_end, 8'h00, 8'h00, 24'h000000, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_end, 8'h00, 8'h00, 24'h000000, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h00, 8'h00, 24'h000040, rand64(), rand64(), 1'b0));
		// Reopen after close; every sector is now pending
		send_packet(make_packet(code_begin, 8'h5A, 8'hA5, 24'($urandom), rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h5A, 8'hA5, 24'h000010, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h5A, 8'hA5, 24'h000FF0, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h5A, 8'hA5, 24'h07F000, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h5A, 8'hA5, 24'h080000, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h5A, 8'hA5, 24'hFFFFFF, rand64(), rand64(), 1'b0));
		// Begin while open replaces the session
		send_packet(make_packet(code_begin, 8'h01, 8'h02, 24'h000200, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h5A, 8'hA5, 24'h002000, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h01, 8'h02, 24'h001800, rand64(), rand64(), 1'b0));
	endtask

	task automatic test_code_extremes();
		program_regs(8'hFF, 8'hFE, 8'hFD, 32'hFFFFFFFF);
		send_packet(make_packet(code_begin, 8'h80, 8'h01, 24'h000400, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h80, 8'h01, 24'h001000, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_data, 8'h80, 8'h01, 24'hFFFFFF, rand64(), rand64(), 1'b0));
		send_packet(make_packet(8'h00, 8'h80, 8'h01, 24'h000000, rand64(), rand64(), 1'b0));
		send_packet(make_packet(code_end, 8'h7F, 8'hFE, 24'h800000, rand64(), rand64(), 1'b0));
	endtask

	task automatic test_code_overlap();
		// All codes equal: every match opens a session
		program_regs(8'h33, 8'h33, 8'h33, 32'h00010000);
		send_packet(make_packet(8'h33, 8'h44, 8'h55, 24'h000100, rand64(), rand64(), 1'b0));
		// End and data equal: end wins, a second one is rejected rather than written
		program_regs(8'h10, 8'h20, 8'h20, 32'h00010000);
		send_packet(make_packet(8'h20, 8'h44, 8'h55, 24'h000100, rand64(), rand64(), 1'b0));
		send_packet(make_packet(8'h20, 8'h44, 8'h55, 24'h000100, rand64(), rand64(), 1'b0));
	endtask

	task automatic test_random_sessions(int n_items, int src_pct, int sink_pct);
		int         sent;
		int         pick;
		logic [7:0] dev, ver, flip;
		src_idle   = src_pct;
		sink_stall = sink_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 80) begin
				dev = rand_byte();
				ver = rand_byte();
				send_packet(make_packet(code_begin, dev, ver, 24'($urandom), rand64(), rand64(),
					1'b0));
				sent++;
				repeat ($urandom_range(1, 12)) begin
					pick = $urandom_range(99);
					flip = 8'($urandom_range(1, 255));
					if (pick < 6)
						send_packet(make_packet(code_data, dev, ver, rand_offset(), rand64(),
							rand64(), 1'b1));
					else if (pick < 10)
						send_packet(make_packet(code_data, dev ^ flip, ver, rand_offset(),
							rand64(), rand64(), 1'b0));
					else if (pick < 13)
						send_packet(make_packet(code_data, dev, ver ^ flip, rand_offset(),
							rand64(), rand64(), 1'b0));
					else
						send_packet(make_packet(code_data, dev, ver, rand_offset(), rand64(),
							rand64(), 1'b0));
					sent++;
				end
				// Leave some sessions open
				if ($urandom_range(99) < 85) begin
					send_packet(make_packet(code_end, rand_byte(), rand_byte(), 24'($urandom),
						rand64(), rand64(), $urandom_range(99) < 5));
					sent++;
				end
			end else begin
				pick = $urandom_range(3);
				case (pick)
					0: send_packet(ota_rx_pkg::in_t'({8'($urandom), rand64(), rand64(),
						24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)}));
					1: send_packet(make_packet(code_end, rand_byte(), rand_byte(),
						24'($urandom), rand64(), rand64(), 1'b0));
					2: send_packet(make_packet(code_data, rand_byte(), rand_byte(),
						rand_offset(), rand64(), rand64(), 1'b0));
					default: send_packet(make_packet(8'($urandom), rand_byte(), rand_byte(),
						24'($urandom), rand64(), rand64(), 1'b0));
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		code_begin    = ota_rx_pkg::BEGIN_CODE_RST;
		code_end      = ota_rx_pkg::END_CODE_RST;
		code_data     = ota_rx_pkg::DATA_CODE_RST;
		base_addr     = ota_rx_pkg::REGION_BASE_RST;
		sess_phase    = ota_rx_pkg::PH_NONE;
		sess_dev      = '0;
		sess_ver      = '0;
		sess_size     = '0;
		sess_sig_lo   = '0;
		sess_sig_hi   = '0;
		erase_pending = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_session_basics();
		test_code_extremes();
		test_code_overlap();

		program_regs(8'h00, 8'h01, 8'h02, 32'h00000000);
		test_random_sessions(360, 0, 0);
		program_random_regs(32'($urandom));
		test_random_sessions(360, 78, 0);
		program_random_regs(32'hFFFF8000);
		test_random_sessions(360, 0, 78);
		program_random_regs(32'($urandom));
		test_random_sessions(360, 11, 11);

		wait_idle();
		repeat (IDLE_GAP) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
